// ----- rtl/cpg_pkg.sv -----
// Shared types and constants for the circle pixel generator.
// Used by every module of the block; depends on nothing else.
package cpg_pkg;

   localparam int IN_COORD_BITS = 8;
   localparam int COLOR_BITS    = 16;
   localparam int PIX_BITS      = 10;
   localparam int QUEUE_DEPTH   = 2;

   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 40;
   localparam int RSP_USED_BITS = 2 * PIX_BITS + COLOR_BITS;

   localparam int REQ_CX_LO    = 0;
   localparam int REQ_CY_LO    = REQ_CX_LO + IN_COORD_BITS;
   localparam int REQ_RAD_LO   = REQ_CY_LO + IN_COORD_BITS;
   localparam int REQ_COLOR_LO = REQ_RAD_LO + IN_COORD_BITS;

   localparam int RSP_PX_LO    = 0;
   localparam int RSP_PY_LO    = RSP_PX_LO + PIX_BITS;
   localparam int RSP_COLOR_LO = RSP_PY_LO + PIX_BITS;

   typedef enum logic [0:0] {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } opcode_type;

   typedef struct packed {
      logic not_full;
      logic not_empty;
   } q_status_type;

endpackage

// ----- rtl/circle_pixel_generator.sv -----
// Top level of the stepped midpoint circle generator: front, queue and back parts.
// Depends on cpg_pkg, cpg_front, cpg_queue and cpg_back.
//
//   channel  direction  ports            content
//   req      in         tdata, tuser     start or advance item, one beat each
//   rsp      out        tdata, tuser,    one pixel per beat, eight per emitting item
//                       tlast
//
// Each start or active advance item yields eight beats, one per cycle while rsp_tready is high, from
// the back part's octant counter.
// The front takes one item per cycle while the two-entry queue has room; an advance while
// idle yields no beat.
// Reset has no clearing pass.
// A stalled rsp_tready holds the output register, the queue fills, and then req_tready drops.
module circle_pixel_generator #(
   parameter int COORD_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // center_x [7:0], center_y [15:8], radius [23:16], pixel_color [39:24]
   input  logic [cpg_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // opcode [0]
   input  logic [0:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pixel_x [9:0], pixel_y [19:10], out_color [35:20], zero fill [39:36]
   output logic [cpg_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // done_res [0]
   output logic [0:0]                        rsp_tuser,
   output logic                              rsp_tlast
);
   import cpg_pkg::*;

   localparam int ENTRY_BITS = 4 * COORD_BITS + COLOR_BITS + 1;

   logic                  accept;
   logic                  push, pop;
   logic [ENTRY_BITS-1:0] push_data, head_data;
   q_status_type          q_status;
   opcode_type            opcode;
   logic [PIX_BITS-1:0]   pixel_x, pixel_y;
   logic [COLOR_BITS-1:0] out_color;
   logic                  last, done_res;

   assign req_tready = q_status.not_full;
   assign accept     = req_tvalid && req_tready;
   assign opcode     = opcode_type'(req_tuser);

   cpg_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .opcode     (opcode),
      .center_x   (req_tdata[REQ_CX_LO +: IN_COORD_BITS]),
      .center_y   (req_tdata[REQ_CY_LO +: IN_COORD_BITS]),
      .radius     (req_tdata[REQ_RAD_LO +: IN_COORD_BITS]),
      .pixel_color(req_tdata[REQ_COLOR_LO +: COLOR_BITS]),
      .push       (push),
      .push_data  (push_data)
   );

   cpg_queue #(
      .WIDTH(ENTRY_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .head_data(head_data),
      .status   (q_status)
   );

   cpg_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .head_data(head_data),
      .pop      (pop),
      .out_ready(rsp_tready),
      .out_valid(rsp_tvalid),
      .pixel_x  (pixel_x),
      .pixel_y  (pixel_y),
      .out_color(out_color),
      .last     (last),
      .done_res (done_res)
   );

   assign rsp_tdata = {{(RSP_DATA_BITS - RSP_USED_BITS){1'b0}}, out_color, pixel_y, pixel_x};
   assign rsp_tuser = done_res;
   assign rsp_tlast = last;

   a_start_queued: assert property (@(posedge clock) disable iff (reset)
      (accept && opcode == OP_START) |=> q_status.not_empty)
      else $error("start beat did not reach the queue");

   a_no_beat_from_empty: assert property (@(posedge clock) disable iff (reset)
      (!q_status.not_empty && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("output beat appeared with an empty queue");

   a_group_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (rsp_tvalid && rsp_tuser == $past(rsp_tuser) &&
          rsp_tdata[RSP_COLOR_LO +: COLOR_BITS] == $past(rsp_tdata[RSP_COLOR_LO +: COLOR_BITS])))
      else $error("pixel group broken before its last beat");

endmodule

// ----- rtl/cpg_queue.sv -----
// Short register queue between the front and back parts of the generator.
// Depends on cpg_pkg for the status struct.
module cpg_queue #(
   parameter int WIDTH = 49,
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [WIDTH-1:0]     push_data,
   input  logic                 pop,
   output logic [WIDTH-1:0]     head_data,
   output cpg_pkg::q_status_type status
);
   import cpg_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data        = entry_ff[rd_ptr_ff];
   assign status.not_full  = (count_ff != CNT_BITS'(DEPTH));
   assign status.not_empty = (count_ff != '0);

endmodule

// ----- rtl/cpg_front.sv -----
// Front part: accepts start and advance items and runs the midpoint update.
// Depends on cpg_pkg; pushes one point per emitting item toward the queue.
module cpg_front #(
   parameter int COORD_BITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  cpg_pkg::opcode_type              opcode,
   input  logic [cpg_pkg::IN_COORD_BITS-1:0] center_x,
   input  logic [cpg_pkg::IN_COORD_BITS-1:0] center_y,
   input  logic [cpg_pkg::IN_COORD_BITS-1:0] radius,
   input  logic [cpg_pkg::COLOR_BITS-1:0]    pixel_color,
   output logic                             push,
   output logic [4*COORD_BITS+cpg_pkg::COLOR_BITS:0] push_data
);
   import cpg_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int DB = COORD_BITS + 4;
   localparam int XW = COORD_BITS + IN_COORD_BITS;

   logic [CB-1:0]         step_x_ff, step_x_in;
   logic [CB-1:0]         step_y_ff, step_y_in;
   logic [DB-1:0]         decision_ff, decision_in;
   logic [CB-1:0]         origin_x_ff, origin_x_in;
   logic [CB-1:0]         origin_y_ff, origin_y_in;
   logic [COLOR_BITS-1:0] held_color_ff, held_color_in;
   logic                  active_ff, active_in;

   logic [XW-1:0] cx_wide, cy_wide, rad_wide;
   logic [DB-1:0] x_twice, y_twice;
   logic          done;

   assign cx_wide  = {{CB{1'b0}}, center_x};
   assign cy_wide  = {{CB{1'b0}}, center_y};
   assign rad_wide = {{CB{1'b0}}, radius};
   assign x_twice  = DB'({step_x_ff, 1'b0});
   assign y_twice  = DB'({step_y_ff, 1'b0});

   always_comb begin
      step_x_in     = step_x_ff;
      step_y_in     = step_y_ff;
      decision_in   = decision_ff;
      origin_x_in   = origin_x_ff;
      origin_y_in   = origin_y_ff;
      held_color_in = held_color_ff;
      push          = 1'b0;
      if (accept) begin
         unique case (opcode)
            OP_START: begin
               origin_x_in   = cx_wide[CB-1:0];
               origin_y_in   = cy_wide[CB-1:0];
               step_y_in     = rad_wide[CB-1:0];
               held_color_in = pixel_color;
               step_x_in     = '0;
               decision_in   = DB'(1) - DB'(rad_wide[CB-1:0]);
               push          = 1'b1;
            end
            OP_ADVANCE: begin
               if (active_ff) begin
                  if (decision_ff[DB-1]) begin
                     decision_in = decision_ff + x_twice + DB'(3);
                  end else begin
                     decision_in = decision_ff + x_twice - y_twice + DB'(5);
                     step_y_in   = step_y_ff - 1'b1;
                  end
                  step_x_in = step_x_ff + 1'b1;
                  push      = 1'b1;
               end
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
      done      = (step_x_in >= step_y_in);
      active_in = push ? !done : active_ff;
   end

   assign push_data = {done, held_color_in, step_y_in, step_x_in, origin_y_in, origin_x_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      step_x_ff     <= step_x_in;
      step_y_ff     <= step_y_in;
      decision_ff   <= decision_in;
      origin_x_ff   <= origin_x_in;
      origin_y_ff   <= origin_y_in;
      held_color_ff <= held_color_in;
   end

endmodule

// ----- rtl/cpg_back.sv -----
// Back part: walks the eight octant pixels of the queue head into the output register.
// Depends on cpg_pkg; pops the queue as it loads the eighth pixel.
module cpg_back #(
   parameter int COORD_BITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cpg_pkg::q_status_type            q_status,
   input  logic [4*COORD_BITS+cpg_pkg::COLOR_BITS:0] head_data,
   output logic                             pop,
   input  logic                             out_ready,
   output logic                             out_valid,
   output logic [cpg_pkg::PIX_BITS-1:0]     pixel_x,
   output logic [cpg_pkg::PIX_BITS-1:0]     pixel_y,
   output logic [cpg_pkg::COLOR_BITS-1:0]   out_color,
   output logic                             last,
   output logic                             done_res
);
   import cpg_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int AW = COORD_BITS + 12;

   logic [2:0]            count_ff, count_in;
   logic                  valid_ff, valid_in;
   logic [PIX_BITS-1:0]   pixel_x_ff, pixel_y_ff;
   logic [COLOR_BITS-1:0] color_ff;
   logic                  last_ff, done_ff;

   logic [CB-1:0]         cx, cy, hx, hy, dx, dy;
   logic [COLOR_BITS-1:0] h_color;
   logic                  h_done;
   logic [AW-1:0]         px_sum, py_sum;
   logic                  load;

   assign {h_done, h_color, hy, hx, cy, cx} = head_data;

   assign load = q_status.not_empty && (!valid_ff || out_ready);
   assign pop  = load && (count_ff == 3'd7);

   always_comb begin
      dx = count_ff[2] ? hy : hx;
      dy = count_ff[2] ? hx : hy;
      if (count_ff[0]) begin
         px_sum = AW'(cx) - AW'(dx);
      end else begin
         px_sum = AW'(cx) + AW'(dx);
      end
      if (count_ff[1]) begin
         py_sum = AW'(cy) - AW'(dy);
      end else begin
         py_sum = AW'(cy) + AW'(dy);
      end
      count_in = load ? count_ff + 1'b1 : count_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pixel_x_ff <= px_sum[PIX_BITS-1:0];
         pixel_y_ff <= py_sum[PIX_BITS-1:0];
         color_ff   <= h_color;
         last_ff    <= (count_ff == 3'd7);
         done_ff    <= h_done;
      end
   end

   assign out_valid = valid_ff;
   assign pixel_x   = pixel_x_ff;
   assign pixel_y   = pixel_y_ff;
   assign out_color = color_ff;
   assign last      = last_ff;
   assign done_res  = done_ff;

endmodule
